// ===== sv/midpoint_ellipse_rasterizer_assert.svh =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer assertion macros
// Shared concurrent assertion forms, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define MER_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mer_pkg.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Field widths, codes and the controller/datapath command and status types.
// ---------------------------------------------------------------------------
package mer_pkg;

	localparam int RADIUS_BITS_DEF = 9;
	localparam int CENTER_W        = 10;
	localparam int ORIGIN_W        = 10;
	localparam int PIX_W           = 12;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;

	localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 10'd320;
	localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = 10'd240;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic [1:0] QUAD_LAST = 2'd3;

	typedef enum logic [1:0] {
		KIND_INIT1,
		KIND_INIT2,
		KIND_STEP1,
		KIND_STEP2
	} kind_t;

	typedef struct packed {
		logic       load_start;
		logic       load_r2;
		logic       mul_sq;
		logic       mul_pt;
		logic       calc;
		logic       upd;
		logic       emit;
		logic       emit_done;
		kind_t      kind;
		logic [1:0] quad;
	} mer_cmd_t;

	typedef struct packed {
		logic go1;
		logic go2;
	} mer_stat_t;

endpackage

// ===== sv/mer_if.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer channels
// Request, response and configuration write channels, valid/ready each.
// ---------------------------------------------------------------------------
interface mer_req_if import mer_pkg::*; #(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic signed [CENTER_W-1:0] center_x;
	logic signed [CENTER_W-1:0] center_y;
	logic [RADIUS_BITS-1:0]     radius_x;
	logic [RADIUS_BITS-1:0]     radius_y;

	modport source (output valid, op, center_x, center_y, radius_x, radius_y, input ready);
	modport sink (input valid, op, center_x, center_y, radius_x, radius_y, output ready);
endinterface

interface mer_rsp_if import mer_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [PIX_W-1:0] pixel_x;
	logic signed [PIX_W-1:0] pixel_y;
	logic                    last;
	logic                    done_res;

	modport source (output valid, pixel_x, pixel_y, last, done_res, input ready);
	modport sink (input valid, pixel_x, pixel_y, last, done_res, output ready);
endinterface

interface mer_cfg_if import mer_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ORIGIN_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/mer_datapath.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Ellipse registers, shared multipliers, decision update and pixel output.
// ---------------------------------------------------------------------------
module mer_datapath import mer_pkg::*; #(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [ORIGIN_W-1:0]        cfg_data,
	input  logic signed [CENTER_W-1:0] center_x,
	input  logic signed [CENTER_W-1:0] center_y,
	input  logic [RADIUS_BITS-1:0]     radius_x,
	input  logic [RADIUS_BITS-1:0]     radius_y,
	input  mer_cmd_t                   cmd,
	output mer_stat_t                  stat,
	output logic signed [PIX_W-1:0]    pixel_x,
	output logic signed [PIX_W-1:0]    pixel_y,
	output logic                       last,
	output logic                       done_res
);

	localparam int PW  = RADIUS_BITS + 1;
	localparam int AW  = 2 * RADIUS_BITS;
	localparam int PRW = AW + PW;
	localparam int DW  = 4 * RADIUS_BITS + 6;
	localparam int SW  = (PW > PIX_W) ? PW : PIX_W;

	logic [ORIGIN_W-1:0]        origin_x_q, origin_y_q;
	logic signed [CENTER_W-1:0] cx_q, cy_q;
	logic [RADIUS_BITS-1:0]     rx_q, ry_q;
	logic [PW-1:0]              x_q, y_q;
	logic [AW-1:0]              a_q, b_q;
	logic [AW+3:0]              a12_q, b12_q;
	logic [PRW-1:0]             pax_q, pby_q;
	logic signed [DW-1:0]       inc_q, dec_q, d_q;
	logic signed [PIX_W-1:0]    px_q, py_q;
	logic                       last_q, done_q;

	logic [AW-1:0]        ml_a, ml_b;
	logic [PW-1:0]        mr_a, mr_b;
	logic [PRW-1:0]       prod_a, prod_b;
	logic signed [DW-1:0] pax_w, pby_w, a_w, b_w, a12_w, b12_w, inc_d, dec_d;
	logic                 dpos;
	logic [SW-1:0]        xs, ys, px_f, py_f;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= ORIGIN_X_RST;
			origin_y_q <= ORIGIN_Y_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_ORIGIN_X) origin_x_q <= cfg_data;
			if (cfg_index == CFG_ORIGIN_Y) origin_y_q <= cfg_data;
		end
	end

	always_comb begin
		ml_a   = cmd.mul_sq ? AW'(ry_q) : a_q;
		mr_a   = cmd.mul_sq ? PW'(ry_q) : x_q;
		ml_b   = cmd.mul_sq ? AW'(rx_q) : b_q;
		mr_b   = cmd.mul_sq ? PW'(rx_q) : y_q;
		prod_a = PRW'(ml_a) * PRW'(mr_a);
		prod_b = PRW'(ml_b) * PRW'(mr_b);
	end

	always_comb begin
		pax_w = DW'(pax_q);
		pby_w = DW'(pby_q);
		a_w   = DW'(a_q);
		b_w   = DW'(b_q);
		a12_w = DW'(a12_q);
		b12_w = DW'(b12_q);
		unique case (cmd.kind)
			KIND_INIT1: begin
				inc_d = (a_w <<< 2) + b_w;
				dec_d = pby_w <<< 2;
			end
			KIND_INIT2: begin
				inc_d = (b_w <<< 2) + a_w;
				dec_d = pax_w <<< 2;
			end
			KIND_STEP1: begin
				inc_d = (pax_w <<< 3) + a12_w;
				dec_d = (pby_w <<< 3) - (b_w <<< 3);
			end
			default: begin
				inc_d = (pby_w <<< 3) + b12_w;
				dec_d = (pax_w <<< 3) - (a_w <<< 3);
			end
		endcase
		stat.go1 = (y_q != '0) && (pax_q <= pby_q);
		stat.go2 = pby_q < pax_q;
		dpos     = d_q > 0;
	end

	always_comb begin
		xs   = SW'(x_q);
		ys   = SW'(y_q);
		px_f = SW'(origin_x_q) + SW'(cx_q) + (cmd.quad[0] ? -xs : xs);
		py_f = SW'(origin_y_q) - SW'(cy_q) + (cmd.quad[1] ? -ys : ys);
	end

	always_ff @(posedge clk) begin
		a12_q <= ((AW+4)'(a_q) << 3) + ((AW+4)'(a_q) << 2);
		b12_q <= ((AW+4)'(b_q) << 3) + ((AW+4)'(b_q) << 2);
		if (cmd.load_start) begin
			cx_q <= center_x;
			cy_q <= center_y;
			rx_q <= radius_x;
			ry_q <= radius_y;
			x_q  <= '0;
			y_q  <= PW'(radius_y);
		end
		if (cmd.load_r2) begin
			x_q <= PW'(rx_q);
			y_q <= '0;
		end
		if (cmd.mul_sq) begin
			a_q <= prod_a[AW-1:0];
			b_q <= prod_b[AW-1:0];
		end
		if (cmd.mul_pt) begin
			pax_q <= prod_a;
			pby_q <= prod_b;
		end
		if (cmd.calc) begin
			inc_q <= inc_d;
			dec_q <= dec_d;
		end
		if (cmd.upd) begin
			unique case (cmd.kind)
				KIND_INIT1, KIND_INIT2: begin
					d_q <= inc_q - dec_q;
				end
				KIND_STEP1: begin
					d_q <= d_q + inc_q - (dpos ? dec_q : '0);
					x_q <= x_q + PW'(1);
					y_q <= y_q - PW'(dpos);
				end
				default: begin
					d_q <= d_q + inc_q - (dpos ? dec_q : '0);
					y_q <= y_q + PW'(1);
					x_q <= x_q - PW'(dpos);
				end
			endcase
		end
		if (cmd.emit) begin
			px_q   <= px_f[PIX_W-1:0];
			py_q   <= py_f[PIX_W-1:0];
			last_q <= cmd.quad == QUAD_LAST;
			done_q <= 1'b0;
		end else if (cmd.emit_done) begin
			px_q   <= '0;
			py_q   <= '0;
			last_q <= 1'b1;
			done_q <= 1'b1;
		end
	end

	assign pixel_x  = px_q;
	assign pixel_y  = py_q;
	assign last     = last_q;
	assign done_res = done_q;

endmodule

// ===== sv/mer_ctrl.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// Sequences load, multiply, compare, update and the four-pixel emission.
// ---------------------------------------------------------------------------
`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_ctrl import mer_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_op,
	output logic      in_ready,
	input  logic      out_ready,
	output logic      out_valid,
	input  mer_stat_t stat,
	output mer_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_MUL,
		ST_CMP,
		ST_UPD,
		ST_EMIT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		REG_R1,
		REG_R2,
		REG_DONE
	} region_t;

	state_t     state_q;
	region_t    region_q;
	kind_t      kind_q;
	logic [1:0] k_q;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	always_comb begin
		accept        = (state_q == ST_IDLE) && in_valid;
		slot_free     = !out_valid_q || out_ready;
		cmd.load_start = accept && (in_op == OP_START);
		cmd.mul_sq    = state_q == ST_SQ;
		cmd.mul_pt    = state_q == ST_MUL;
		cmd.calc      = state_q == ST_CMP;
		cmd.load_r2   = (state_q == ST_CMP) && (kind_q == KIND_STEP1) && !stat.go1;
		cmd.upd       = state_q == ST_UPD;
		cmd.emit      = (state_q == ST_EMIT) && slot_free;
		cmd.emit_done = (state_q == ST_DONE) && slot_free;
		cmd.kind      = kind_q;
		cmd.quad      = k_q;
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			region_q    <= REG_DONE;
			kind_q      <= KIND_INIT1;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit || cmd.emit_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_op == OP_START) begin
							kind_q   <= KIND_INIT1;
							region_q <= REG_R1;
							state_q  <= ST_SQ;
						end else begin
							unique case (region_q)
								REG_R1: begin
									kind_q  <= KIND_STEP1;
									state_q <= ST_MUL;
								end
								REG_R2: begin
									kind_q  <= KIND_STEP2;
									state_q <= ST_MUL;
								end
								default: state_q <= ST_DONE;
							endcase
						end
					end
				end
				ST_SQ:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_CMP;
				ST_CMP: begin
					unique case (kind_q)
						KIND_STEP1: begin
							if (stat.go1) begin
								state_q <= ST_UPD;
							end else begin
								// restart at the end of the horizontal axis
								kind_q   <= KIND_INIT2;
								region_q <= REG_R2;
								state_q  <= ST_MUL;
							end
						end
						KIND_STEP2: begin
							if (stat.go2) begin
								state_q <= ST_UPD;
							end else begin
								region_q <= REG_DONE;
								state_q  <= ST_DONE;
							end
						end
						default: state_q <= ST_UPD;
					endcase
				end
				ST_UPD: begin
					k_q     <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						k_q <= k_q + 2'd1;
						if (k_q == QUAD_LAST) state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MER_ASSERT_NEXT(a_start_enters_r1, clk, arst_n, accept && (in_op == OP_START), (region_q == REG_R1) && (state_q == ST_SQ), "start request did not enter region one")
	`MER_ASSERT_NEXT(a_done_step, clk, arst_n, accept && (in_op == OP_STEP) && (region_q == REG_DONE), state_q == ST_DONE, "step after finish did not report done")
	`MER_ASSERT_NEXT(a_done_sticky, clk, arst_n, (region_q == REG_DONE) && !cmd.load_start, region_q == REG_DONE, "finished ellipse resumed without start")
	`MER_ASSERT_NEXT(a_last_pixel, clk, arst_n, cmd.emit && (k_q == QUAD_LAST), (state_q == ST_IDLE) && out_valid_q, "fourth pixel did not end the request")
	`MER_ASSERT_IMPL(a_load_free_slot, clk, arst_n, cmd.emit || cmd.emit_done, (state_q == ST_EMIT) || (state_q == ST_DONE), "output loaded outside emission")

endmodule

// ===== sv/midpoint_ellipse_rasterizer.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Integer midpoint ellipse walk emitting four mirrored screen pixels per point.
// ---------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | op, center_x, center_y, radius_x, radius_y
//  rsp     | out | pixel_x, pixel_y, last, done_res
//  cfg     | in  | index (0 origin_x, 1 origin_y), data; always ready
//
//  Start request: square, multiply, compare, update, then one pixel per cycle from
//  the output register while the response is not stalled, up to the fourth pixel.
//  Step request: multiply, compare, update, emission; the step that changes region
//  runs multiply and compare twice; the step that ends region two goes from compare
//  to done; once finished, straight to done. All share the multiply/compare/update
//  sequence and the one-pixel output register. Reset puts the walk in the finished
//  state, origin (320,240). A stalled response holds the emission; the next request
//  is taken while the last response still waits.
// ---------------------------------------------------------------------------
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	mer_req_if.sink      req,
	mer_rsp_if.source    rsp,
	mer_cfg_if.sink      cfg
);

	mer_cmd_t  cmd;
	mer_stat_t stat;

	assign cfg.ready = 1'b1;

	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (req.op),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	mer_datapath #(
		.RADIUS_BITS (RADIUS_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.center_x  (req.center_x),
		.center_y  (req.center_y),
		.radius_x  (req.radius_x),
		.radius_y  (req.radius_y),
		.cmd       (cmd),
		.stat      (stat),
		.pixel_x   (rsp.pixel_x),
		.pixel_y   (rsp.pixel_y),
		.last      (rsp.last),
		.done_res  (rsp.done_res)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer testbench
// Drives start and step requests with random gaps and checks every emitted
// pixel against a cycle-free model of the ellipse walk. A short directed set
// covers the degenerate radii and the field extremes. Random phases follow,
// one for each origin setting. Output back-pressure is random, with one long
// hold-off that fills the block.
// ---------------------------------------------------------------------------
module tb;
	import mer_pkg::*;

	typedef enum logic [1:0] {
		ARC_UPPER,
		ARC_SIDE,
		ARC_DONE
	} arc_t;

	typedef struct {
		logic signed [PIX_W-1:0] px;
		logic signed [PIX_W-1:0] py;
		logic                    last;
		logic                    done;
	} screen_pixel_t;

	class ellipse_tracker;
		logic [ORIGIN_W-1:0]        org_x;
		logic [ORIGIN_W-1:0]        org_y;
		logic signed [CENTER_W-1:0] ctr_x;
		logic signed [CENTER_W-1:0] ctr_y;
		logic [RADIUS_BITS_DEF-1:0] rad_x;
		logic [RADIUS_BITS_DEF-1:0] rad_y;
		int                         pt_x;
		int                         pt_y;
		longint                     dec;
		arc_t                       arc;
		screen_pixel_t              pending_pixels[$];
		int                         mismatches;

		function new();
			org_x = ORIGIN_X_RST;
			org_y = ORIGIN_Y_RST;
			ctr_x = '0;
			ctr_y = '0;
			rad_x = '0;
			rad_y = '0;
			pt_x = 0;
			pt_y = 0;
			dec = 0;
			arc = ARC_DONE;
			mismatches = 0;
		endfunction

		function void write_origin(logic [CFG_IDX_W-1:0] idx, logic [ORIGIN_W-1:0] val);
			if (idx == CFG_ORIGIN_X)
				org_x = val;
			else if (idx == CFG_ORIGIN_Y)
				org_y = val;
		endfunction

		function void push_quad();
			screen_pixel_t p;
			int            k;
			int            sx;
			int            sy;
			for (k = 0; k < 4; k++) begin
				sx = (k & 1) ? -pt_x : pt_x;
				sy = (k & 2) ? -pt_y : pt_y;
				p.px = PIX_W'(int'(org_x) + int'(ctr_x) + sx);
				p.py = PIX_W'(int'(org_y) - int'(ctr_y) + sy);
				p.last = (k == int'(QUAD_LAST));
				p.done = 1'b0;
				pending_pixels.push_back(p);
			end
		endfunction

		function void take_request(logic op, logic signed [CENTER_W-1:0] cx,
				logic signed [CENTER_W-1:0] cy, logic [RADIUS_BITS_DEF-1:0] rx,
				logic [RADIUS_BITS_DEF-1:0] ry);
			longint        a;
			longint        b;
			longint        x;
			longint        y;
			screen_pixel_t p;
			if (op == OP_START) begin
				ctr_x = cx;
				ctr_y = cy;
				rad_x = rx;
				rad_y = ry;
				a = longint'(rad_y) * longint'(rad_y);
				b = longint'(rad_x) * longint'(rad_x);
				pt_x = 0;
				pt_y = int'(rad_y);
				dec = 4 * a - 4 * b * longint'(rad_y) + b;
				arc = ARC_UPPER;
				push_quad();
				return;
			end
			a = longint'(rad_y) * longint'(rad_y);
			b = longint'(rad_x) * longint'(rad_x);
			x = pt_x;
			y = pt_y;
			if (arc == ARC_UPPER) begin
				if (y != 0 && a * x <= b * y) begin
					x = x + 1;
					if (dec <= 0) begin
						dec = dec + 8 * a * x + 4 * a;
					end else begin
						y = y - 1;
						dec = dec + 8 * a * x + 4 * a - 8 * b * y;
					end
				end else begin
					x = longint'(rad_x);
					y = 0;
					dec = 4 * b - 4 * a * x + a;
					arc = ARC_SIDE;
				end
				pt_x = int'(x);
				pt_y = int'(y);
				push_quad();
				return;
			end
			if (arc == ARC_SIDE) begin
				if (b * y < a * x) begin
					y = y + 1;
					if (dec <= 0) begin
						dec = dec + 8 * b * y + 4 * b;
					end else begin
						x = x - 1;
						dec = dec + 8 * b * y + 4 * b - 8 * a * x;
					end
					pt_x = int'(x);
					pt_y = int'(y);
					push_quad();
					return;
				end
				arc = ARC_DONE;
			end
			p.px = '0;
			p.py = '0;
			p.last = 1'b1;
			p.done = 1'b1;
			pending_pixels.push_back(p);
		endfunction

		function void check_pixel(logic signed [PIX_W-1:0] px, logic signed [PIX_W-1:0] py,
				logic last, logic done);
			screen_pixel_t e;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel x=%0d y=%0d last=%0b done=%0b",
					$time, px, py, last, done);
				mismatches++;
				return;
			end
			e = pending_pixels.pop_front();
			if (px !== e.px) begin
				$display("%0t: pixel_x expected %0d actual %0d", $time, e.px, px);
				mismatches++;
			end
			if (py !== e.py) begin
				$display("%0t: pixel_y expected %0d actual %0d", $time, e.py, py);
				mismatches++;
			end
			if (last !== e.last) begin
				$display("%0t: last expected %0b actual %0b", $time, e.last, last);
				mismatches++;
			end
			if (done !== e.done) begin
				$display("%0t: done_res expected %0b actual %0b", $time, e.done, done);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic no_idle;
	int   pixels_seen;

	ellipse_tracker tracker = new();

	mer_req_if req_ch ();
	mer_rsp_if rsp_ch ();
	mer_cfg_if cfg_ch ();

	midpoint_ellipse_rasterizer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic send_request(logic op, logic signed [CENTER_W-1:0] cx,
			logic signed [CENTER_W-1:0] cy, logic [RADIUS_BITS_DEF-1:0] rx,
			logic [RADIUS_BITS_DEF-1:0] ry);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.center_x <= cx;
		req_ch.center_y <= cy;
		req_ch.radius_x <= rx;
		req_ch.radius_y <= ry;
		do @(posedge clk); while (!req_ch.ready);
		tracker.take_request(op, cx, cy, rx, ry);
	endtask

	task automatic send_step();
		send_request(OP_STEP, CENTER_W'($urandom), CENTER_W'($urandom),
			RADIUS_BITS_DEF'($urandom), RADIUS_BITS_DEF'($urandom));
	endtask

	task automatic send_start(logic signed [CENTER_W-1:0] cx, logic signed [CENTER_W-1:0] cy,
			logic [RADIUS_BITS_DEF-1:0] rx, logic [RADIUS_BITS_DEF-1:0] ry);
		send_request(OP_START, cx, cy, rx, ry);
	endtask

	task automatic send_steps(int n);
		int k;
		for (k = 0; k < n; k++)
			send_step();
	endtask

	task automatic write_origin(logic [ORIGIN_W-1:0] ox, logic [ORIGIN_W-1:0] oy);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_ORIGIN_X;
		cfg_ch.data <= ox;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.write_origin(CFG_ORIGIN_X, ox);
		cfg_ch.index <= CFG_ORIGIN_Y;
		cfg_ch.data <= oy;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.write_origin(CFG_ORIGIN_Y, oy);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (tracker.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic run_random(int n);
		int                         sent;
		int                         k;
		int                         steps;
		logic [RADIUS_BITS_DEF-1:0] rx;
		logic [RADIUS_BITS_DEF-1:0] ry;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				send_step();
				sent++;
			end else begin
				if ($urandom_range(0, 6) == 0) begin
					rx = RADIUS_BITS_DEF'($urandom_range(0, 511));
					ry = RADIUS_BITS_DEF'($urandom_range(0, 511));
				end else begin
					rx = RADIUS_BITS_DEF'($urandom_range(0, 10));
					ry = RADIUS_BITS_DEF'($urandom_range(0, 10));
				end
				send_start(CENTER_W'($urandom), CENTER_W'($urandom), rx, ry);
				sent++;
				steps = $urandom_range(0, 30);
				for (k = 0; k < steps && sent < n; k++) begin
					send_step();
					sent++;
				end
			end
		end
	endtask

	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		pixels_seen = 0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 17);
			if (pixels_seen == 200)
				stall = 400;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			tracker.check_pixel(rsp_ch.pixel_x, rsp_ch.pixel_y, rsp_ch.last, rsp_ch.done_res);
			pixels_seen++;
		end
	end

	initial begin
		arst_n <= 1'b0;
		no_idle = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_STEP;
		req_ch.center_x <= '0;
		req_ch.center_y <= '0;
		req_ch.radius_x <= '0;
		req_ch.radius_y <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_ORIGIN_X;
		cfg_ch.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_step();
		send_start(10'sd0, 10'sd0, 9'd3, 9'd2);
		send_steps(8);
		send_start(10'sd5, -10'sd7, 9'd4, 9'd0);
		send_steps(3);
		send_start(-10'sd3, 10'sd9, 9'd0, 9'd3);
		send_steps(4);
		send_start(-10'sd512, 10'sd511, 9'd511, 9'd511);
		send_steps(2);
		send_start(10'sd511, -10'sd512, 9'd0, 9'd0);
		send_steps(2);
		drain();

		write_origin(10'd0, 10'd0);
		run_random(50);
		drain();

		write_origin(10'd1023, 10'd1023);
		run_random(50);
		drain();

		no_idle = 1'b1;
		write_origin(10'd1023, 10'd0);
		run_random(50);
		drain();
		no_idle = 1'b0;

		write_origin(ORIGIN_W'($urandom), ORIGIN_W'($urandom));
		run_random(60);
		drain();

		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
